[design/ipv6f_pkg.sv]
package ipv6f_pkg;

  localparam int NUM_GROUPS = 8;
  localparam int GROUP_W    = 16;
  localparam int GIDX_W     = 3;
  localparam int CHAR_W     = 7;
  localparam int ADDR_W     = NUM_GROUPS * GROUP_W;

  localparam logic [CHAR_W-1:0] COLON_CHAR       = 7'h3A;
  localparam logic [CHAR_W-1:0] DIGIT_BASE       = 7'h30;
  localparam logic [CHAR_W-1:0] LETTER_BASE      = 7'h57;  // 'a' minus ten
  localparam logic [3:0]        NIBBLE_TEN       = 4'd10;

  // per-group result of one lane
  typedef struct packed {
    logic       zero;  // group is all zeros
    logic [2:0] ndig;  // hex digits without leading zeros, 1..4
  } lane_info_t;

  // what one group contributes to the text
  typedef struct packed {
    logic [1:0] lead;   // colons ahead of the digits
    logic [2:0] ndig;   // digits written, 0 inside the compressed run
    logic       trail;  // separator colon after the digits
  } grp_desc_t;

  // merged plan for a whole address
  typedef struct packed {
    grp_desc_t [NUM_GROUPS-1:0] desc;
    logic [NUM_GROUPS-1:0]      nonempty;
    logic [GIDX_W-1:0]          first_g;
    logic [GIDX_W-1:0]          last_g;
  } plan_t;

  // lower-case hex digit to ASCII
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] wide;
    wide = {3'b000, nib};
    if (nib < NIBBLE_TEN) begin
      hex_char = DIGIT_BASE + wide;
    end else begin
      hex_char = LETTER_BASE + wide;
    end
  endfunction

endpackage

[design/ipv6f_lane.sv]
module ipv6f_lane
  import ipv6f_pkg::*;
(
  input  logic [GROUP_W-1:0] grp,
  output lane_info_t         info
);

  // count significant hex digits; zero still prints one digit
  always_comb begin
    info.zero = (grp == '0);
    if (grp[15:12] != 4'd0) begin
      info.ndig = 3'd4;
    end else if (grp[11:8] != 4'd0) begin
      info.ndig = 3'd3;
    end else if (grp[7:4] != 4'd0) begin
      info.ndig = 3'd2;
    end else begin
      info.ndig = 3'd1;
    end
  end

endmodule

[design/ipv6f_merge.sv]
module ipv6f_merge
  import ipv6f_pkg::*;
(
  input  lane_info_t [NUM_GROUPS-1:0] lanes,
  output plan_t                       plan
);

  logic [3:0]            run [NUM_GROUPS];
  logic [3:0]            best;
  logic                  compress;
  logic [NUM_GROUPS-1:0] endm;
  logic [3:0]            nends;
  logic [GIDX_W-1:0]     first_e;
  logic [GIDX_W-1:0]     last_e;
  logic [GIDX_W-1:0]     prev_e;
  logic [GIDX_W-1:0]     pos;
  logic [3:0]            start_w;
  logic [GIDX_W-1:0]     start_g;

  // zero-run lengths ending at each group, and the longest
  always_comb begin
    run[0] = lanes[0].zero ? 4'd1 : 4'd0;
    for (int i = 1; i < NUM_GROUPS; i++) begin
      if (!lanes[i].zero) begin
        run[i] = 4'd0;
      end else begin
        run[i] = run[i-1] + 4'd1;
      end
    end
    best = 4'd0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if (run[i] > best) begin
        best = run[i];
      end
    end
    compress = (best >= 4'd2);
  end

  // locate the runs of maximal length
  always_comb begin
    nends   = 4'd0;
    first_e = '0;
    last_e  = '0;
    prev_e  = '0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      endm[i] = compress && (run[i] == best);
    end
    for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
      if (endm[i]) begin
        first_e = GIDX_W'(i);
      end
    end
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if (endm[i]) begin
        nends  = nends + 4'd1;
        prev_e = last_e;
        last_e = GIDX_W'(i);
      end
    end
  end

  // pick the run; a trailing tie prefers the earlier, bar a sole rival starting at 0
  always_comb begin
    pos = last_e;
    if (last_e == GIDX_W'(NUM_GROUPS - 1) && nends > 4'd1) begin
      if (nends != 4'd2 || ({1'b0, first_e} + 4'd1) != best) begin
        pos = prev_e;
      end
    end
    start_w = {1'b0, pos} + 4'd1 - best;
    start_g = start_w[GIDX_W-1:0];
  end

  // per-group contribution and the span of groups that print anything
  always_comb begin
    logic inreg;
    plan.first_g = '0;
    plan.last_g  = '0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      inreg = compress && (GIDX_W'(i) >= start_g) && (GIDX_W'(i) <= pos);
      if (compress && GIDX_W'(i) == start_g) begin
        plan.desc[i].lead = (start_g == '0) ? 2'd2 : 2'd1;
      end else begin
        plan.desc[i].lead = 2'd0;
      end
      plan.desc[i].ndig  = inreg ? 3'd0 : lanes[i].ndig;
      plan.desc[i].trail = !inreg && (i != NUM_GROUPS - 1);
      plan.nonempty[i]   = (plan.desc[i].lead != 2'd0) || (plan.desc[i].ndig != 3'd0)
                           || plan.desc[i].trail;
    end
    for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
      if (plan.nonempty[i]) begin
        plan.first_g = GIDX_W'(i);
      end
    end
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if (plan.nonempty[i]) begin
        plan.last_g = GIDX_W'(i);
      end
    end
  end

endmodule

[design/ipv6f_serializer.sv]
module ipv6f_serializer
  import ipv6f_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_valid,
  output logic              load_ready,
  input  logic [ADDR_W-1:0] load_data,
  input  plan_t             load_plan,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  logic                                busy_r, busy_nxt;
  logic [GIDX_W-1:0]                   g_r, g_nxt;
  logic [2:0]                          p_r, p_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]                   out_char_r;
  logic                                out_last_r;
  logic [NUM_GROUPS-1:0][GROUP_W-1:0]  val_r;
  plan_t                               plan_r;

  grp_desc_t         cur;
  logic [GROUP_W-1:0] cur_val;
  logic [2:0]        len;
  logic [2:0]        off;
  logic [2:0]        kk;
  logic [1:0]        k;
  logic [CHAR_W-1:0] ch;
  logic              is_end;
  logic              is_last;
  logic              emit;
  logic              load;
  logic [GIDX_W-1:0] next_g;

  // decode the character at the current group and position
  always_comb begin
    cur     = plan_r.desc[g_r];
    cur_val = val_r[g_r];
    len     = {1'b0, cur.lead} + cur.ndig + {2'b00, cur.trail};
    off     = p_r - {1'b0, cur.lead};
    kk      = cur.ndig - 3'd1 - off;
    k       = kk[1:0];
    if (p_r < {1'b0, cur.lead}) begin
      ch = COLON_CHAR;
    end else if (p_r < ({1'b0, cur.lead} + cur.ndig)) begin
      ch = hex_char(cur_val[{k, 2'b00} +: 4]);
    end else begin
      ch = COLON_CHAR;
    end
    is_end  = (p_r == len - 3'd1);
    is_last = is_end && (g_r == plan_r.last_g);
  end

  // next group that prints anything
  always_comb begin
    next_g = g_r;
    for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
      if (plan_r.nonempty[i] && GIDX_W'(i) > g_r) begin
        next_g = GIDX_W'(i);
      end
    end
  end

  assign emit       = busy_r && (!out_valid_r || out_ready);
  assign load_ready = !busy_r || (emit && is_last);
  assign load       = load_valid && load_ready;

  // advance through the text, reload on the final character
  always_comb begin
    busy_nxt      = busy_r;
    g_nxt         = g_r;
    p_nxt         = p_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end else if (is_end) begin
        g_nxt = next_g;
        p_nxt = 3'd0;
      end else begin
        p_nxt = p_r + 3'd1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      g_nxt    = load_plan.first_g;
      p_nxt    = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      g_r         <= '0;
      p_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      g_r         <= g_nxt;
      p_r         <= p_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the address and its plan; capture each emitted beat
  always_ff @(posedge clk) begin
    if (load) begin
      val_r  <= load_data;
      plan_r <= load_plan;
    end
    if (emit) begin
      out_char_r <= ch;
      out_last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

[design/ipv6_address_text_formatter_unit.sv]
// Channel  Dir  Ports                          Beat contents
// in       in   in_tvalid/in_tready/in_tdata   one address, group_1 in bits 15:0
// out      out  out_tvalid/out_tready/out_*    one ASCII character, tlast on the final one
//
// Each address yields 2 to 39 characters, one per cycle while out_tready holds high.
// Back to back addresses stream with no gap: the next plan loads on the final character.
// A taken address passes the lane stage register and serializer, then the output register.
// Reset (synchronous, active low) empties the lane stage, serializer and output register.
// out_tready low holds the output register; in_tready drops while a full lane stage waits.
module ipv6_address_text_formatter_unit
  import ipv6f_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [ADDR_W-1:0] in_tdata,   // group_1[15:0] .. group_8[127:112]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // char_code[6:0], zero [7]
  output logic              out_tlast   // last_char
);

  lane_info_t [NUM_GROUPS-1:0] lane_info;
  lane_info_t [NUM_GROUPS-1:0] s1_lane_r;
  logic [ADDR_W-1:0]           s1_data_r;
  logic                        s1_valid_r, s1_valid_nxt;
  plan_t                       plan;
  logic                        ser_ready;
  logic                        in_acc;
  logic [CHAR_W-1:0]           out_char;

  // one lane per group
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_lane
    ipv6f_lane u_lane (
      .grp  (in_tdata[g*GROUP_W +: GROUP_W]),
      .info (lane_info[g])
    );
  end

  assign in_tready = !s1_valid_r || ser_ready;
  assign in_acc    = in_tvalid && in_tready;

  // lane stage occupancy
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (ser_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata;
      s1_lane_r <= lane_info;
    end
  end

  // combine lane results into the text plan
  ipv6f_merge u_merge (
    .lanes (s1_lane_r),
    .plan  (plan)
  );

  ipv6f_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s1_valid_r),
    .load_ready (ser_ready),
    .load_data  (s1_data_r),
    .load_plan  (plan),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_char),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ipv6f_pkg::*;

  localparam int RANDOM_ADDRS = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_AT      = 300;   // addresses taken before the long output stall
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_FROM   = 150;   // address window with no idling on either side
  localparam int QUIET_TO     = 250;
  localparam int IDLE_PCT     = 28;
  localparam int TAIL_CYCLES  = 10;

  typedef logic [GROUP_W-1:0] group_t;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [ADDR_W-1:0] in_tdata = '0;    // group_1 .. group_8, 16 bits each
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;        // char_code[6:0], zero [7]
  logic              out_tlast;        // last_char

  logic [ADDR_W-1:0] pending_addrs[$];
  text_char_t        expected_chars[$];
  int                addrs_taken = 0;
  int                errors = 0;
  int                cycles = 0;
  int                hold_left = 0;
  bit                hold_done = 1'b0;
  bit                quiet;

  ipv6_address_text_formatter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  assign quiet = (addrs_taken >= QUIET_FROM) && (addrs_taken < QUIET_TO);

  // pack eight groups, group_1 in the low bits
  function automatic logic [ADDR_W-1:0] pack_addr(input group_t g1, g2, g3, g4,
                                                  input group_t g5, g6, g7, g8);
    return {g8, g7, g6, g5, g4, g3, g2, g1};
  endfunction

  // random group, zero-heavy so that runs of zero groups are common
  function automatic group_t rand_group(input int zero_pct);
    int ndig;
    group_t mask;
    if ($urandom_range(99) < zero_pct) begin
      return '0;
    end
    ndig = $urandom_range(1, 4);
    mask = group_t'((32'h1 << (4 * ndig)) - 1);
    return group_t'($urandom) & mask;
  endfunction

  // append one group as hex with leading zeros dropped
  function automatic void emit_group(input group_t value, ref text_char_t line[$]);
    logic [3:0] nib;
    bit started;
    text_char_t c;
    started = 1'b0;
    for (int k = 3; k >= 0; k--) begin
      nib = value[4*k +: 4];
      if (nib != 0 || started || k == 0) begin
        c.code = (nib < 10) ? DIGIT_BASE + CHAR_W'(nib) : LETTER_BASE + CHAR_W'(nib);
        c.last = 1'b0;
        line.insert(line.size(), c);
        started = 1'b1;
      end
    end
  endfunction

  function automatic void emit_colon(ref text_char_t line[$]);
    text_char_t c;
    c.code = COLON_CHAR;
    c.last = 1'b0;
    line.insert(line.size(), c);
  endfunction

  // work out the text of one address and queue its characters
  function automatic void predict_text(input logic [ADDR_W-1:0] addr);
    group_t grp[1:NUM_GROUPS];
    int run[0:NUM_GROUPS];
    int ends[$];
    int best;
    int pos;
    int i;
    text_char_t line[$];
    best = 0;
    run[0] = 0;
    for (i = 1; i <= NUM_GROUPS; i++) begin
      grp[i] = addr[GROUP_W*(i-1) +: GROUP_W];
      run[i] = (grp[i] == 0) ? run[i-1] + 1 : 0;
      if (run[i] > best) best = run[i];
    end

    if (best <= 1) begin
      // nothing to compress
      for (i = 1; i <= NUM_GROUPS; i++) begin
        emit_group(grp[i], line);
        if (i != NUM_GROUPS) emit_colon(line);
      end
    end else begin
      for (i = 1; i <= NUM_GROUPS; i++) begin
        if (run[i] == best) ends.insert(ends.size(), i);
      end
      // pick the run: last one, except a trailing run loses a tie
      // unless the only rival starts at the first group
      pos = ends[ends.size()-1];
      if (pos == NUM_GROUPS && ends.size() > 1) begin
        if (ends.size() != 2 || ends[0] != best) pos = ends[ends.size()-2];
      end
      if (pos == best) emit_colon(line);
      for (i = 1; i <= NUM_GROUPS; i++) begin
        if (i == pos - best + 1) begin
          emit_colon(line);
          i = pos;
        end else begin
          emit_group(grp[i], line);
          if (i != NUM_GROUPS) emit_colon(line);
        end
      end
    end

    line[line.size()-1].last = 1'b1;
    foreach (line[k]) expected_chars.insert(expected_chars.size(), line[k]);
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  // stimulus, reset and end of run
  initial begin
    logic [ADDR_W-1:0] a;
    int zero_pct;
    // directed addresses
    pending_addrs.insert(pending_addrs.size(), pack_addr(0, 0, 0, 0, 0, 0, 0, 0));
    pending_addrs.insert(pending_addrs.size(), pack_addr('hffff, 'hffff, 'hffff, 'hffff,
                                                         'hffff, 'hffff, 'hffff, 'hffff));
    pending_addrs.insert(pending_addrs.size(), pack_addr(0, 1, 0, 2, 0, 3, 0, 4));
    pending_addrs.insert(pending_addrs.size(), pack_addr(1, 2, 3, 4, 5, 6, 7, 0));
    pending_addrs.insert(pending_addrs.size(), pack_addr(0, 0, 1, 2, 3, 4, 5, 6));
    pending_addrs.insert(pending_addrs.size(), pack_addr(1, 2, 3, 4, 5, 6, 0, 0));
    pending_addrs.insert(pending_addrs.size(), pack_addr(0, 0, 1, 2, 3, 4, 0, 0));
    pending_addrs.insert(pending_addrs.size(), pack_addr(1, 0, 0, 2, 3, 4, 0, 0));
    pending_addrs.insert(pending_addrs.size(), pack_addr(0, 0, 1, 0, 0, 2, 0, 0));
    pending_addrs.insert(pending_addrs.size(), pack_addr(1, 0, 0, 2, 0, 0, 3, 4));
    pending_addrs.insert(pending_addrs.size(), pack_addr(0, 0, 0, 1, 0, 0, 0, 2));
    pending_addrs.insert(pending_addrs.size(), pack_addr(0, 0, 0, 0, 0, 0, 0, 1));
    pending_addrs.insert(pending_addrs.size(), pack_addr(1, 0, 0, 0, 0, 0, 0, 0));
    pending_addrs.insert(pending_addrs.size(), pack_addr(1, 0, 0, 2, 0, 0, 0, 3));
    pending_addrs.insert(pending_addrs.size(),
                         pack_addr('hf, 'hff, 'hfff, 'hffff, 'h1000, 'h100, 'h10, 1));
    pending_addrs.insert(pending_addrs.size(),
                         pack_addr('habcd, 'hef01, 'h2345, 'h6789, 'ha, 'hb, 'hc, 'hd));
    pending_addrs.insert(pending_addrs.size(), pack_addr('h8000, 0, 0, 0, 'h7fff, 0, 0, 1));
    pending_addrs.insert(pending_addrs.size(), pack_addr(1, 0, 0, 0, 0, 0, 0, 1));
    pending_addrs.insert(pending_addrs.size(), pack_addr(0, 0, 0, 0, 0, 0, 1, 0));
    pending_addrs.insert(pending_addrs.size(), pack_addr(0, 1, 0, 0, 1, 0, 0, 0));
    pending_addrs.insert(pending_addrs.size(), pack_addr(0, 0, 0, 1, 2, 0, 0, 0));
    pending_addrs.insert(pending_addrs.size(),
                         pack_addr(0, 'h5a5a, 0, 'ha5a5, 0, 0, 'h0f0f, 0));

    // random addresses, mostly zero-heavy, some dense
    for (int n = 0; n < RANDOM_ADDRS; n++) begin
      zero_pct = ($urandom_range(99) < 80) ? $urandom_range(25, 60) : 5;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        a[GROUP_W*g +: GROUP_W] = rand_group(zero_pct);
      end
      pending_addrs.insert(pending_addrs.size(), a);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // drain
    while (pending_addrs.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS ipv6_address_text_formatter_unit");
    end else begin
      $display("FAIL ipv6_address_text_formatter_unit");
    end
    $finish;
  end

  // address driver: hold the beat until taken, then offer the next or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_text(in_tdata);
        addrs_taken <= addrs_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_addrs.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_addrs.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // character receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!hold_done && addrs_taken >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left  = hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // compare each character beat with the oldest expected one
  always @(posedge clk) begin : char_check
    text_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $error("char_code: none expected, got %h (last_char %b)", out_tdata[6:0], out_tlast);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata[CHAR_W-1:0] !== want.code) begin
          $error("char_code: expected %h, got %h", want.code, out_tdata[CHAR_W-1:0]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_char: expected %b, got %b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL ipv6_address_text_formatter_unit");
      $finish;
    end
  end

endmodule

[files.f]
design/ipv6f_pkg.sv
design/ipv6f_lane.sv
design/ipv6f_merge.sv
design/ipv6f_serializer.sv
design/ipv6_address_text_formatter_unit.sv
tb/tb_top.sv
